[rtl/core/ssca_pkg.sv]
package ssca_pkg;

  localparam int N_BUCKETS_DEF   = 8;
  localparam int MAX_BLOCKS_DEF  = 1024;
  localparam int POOL_SLOTS      = 8;
  localparam int SIZE_W          = 16;
  localparam int BB_W            = 17;
  localparam int CNT_MAX_W       = 13;
  localparam int OFF_W           = BB_W + CNT_MAX_W;
  localparam int ADDR_W          = 48;
  localparam int ALIGN_MAX_LOG   = 12;
  localparam int SETTLE_CYCLES   = POOL_SLOTS + 3;
  localparam int QUEUE_DEPTH     = 2;
  localparam int APB_AW          = 6;
  localparam int APB_DW          = 64;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [2:0] {
    REG_SIZES_LO   = 3'd0,
    REG_SIZES_HI   = 3'd1,
    REG_BUCKET_CNT = 3'd2,
    REG_ALIGN_LOG2 = 3'd3,
    REG_HEAP_BASE  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_ALIGN     = 3'd2,
    ST_NO_FIT    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_OUTSIDE   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    K_FINAL = 2'd0,
    K_ALLOC = 2'd1,
    K_FREE  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        cmd;
    logic [31:0] req_size;
    logic [12:0] req_align;
    logic [47:0] free_address;
  } in_t;

  typedef struct packed {
    logic [47:0] block_address;
    logic [2:0]  bucket;
    logic [2:0]  status;
  } out_t;

  typedef struct packed {
    kind_t              kind;
    logic [2:0]         pool;
    status_t            status;
    logic [OFF_W-1:0]   off;
  } qent_t;

  function automatic logic [CNT_MAX_W-1:0] block_total(input logic [SIZE_W-1:0] s);
    logic [CNT_MAX_W-1:0] n;
    if (s <= 16'd32)        n = 13'd1024;
    else if (s <= 16'd128)  n = 13'd512;
    else if (s <= 16'd512)  n = 13'd256;
    else if (s <= 16'd2048) n = 13'd128;
    else                    n = 13'd64;
    return n;
  endfunction

  function automatic logic [BB_W-1:0] block_bytes(input logic [SIZE_W-1:0] s,
                                                  input logic [3:0] al);
    logic [BB_W-1:0] b;
    logic [BB_W-1:0] a;
    b = (s < 16'd8) ? 17'd8 : {1'b0, s};
    a = 17'd1 << al;
    return (b + a - 17'd1) & ~(a - 17'd1);
  endfunction

endpackage

[rtl/core/ssca_cfg.sv]
module ssca_cfg
  import ssca_pkg::*;
#(
  parameter int POOLS      = N_BUCKETS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int LEN_W      = BB_W + CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [APB_AW-1:0]   cfg_paddr,
  input  logic [APB_DW-1:0]   cfg_pwdata,
  output logic [APB_DW-1:0]   cfg_prdata,
  output logic                cfg_pready,
  output logic [SIZE_W-1:0]   size_o  [POOL_SLOTS],
  output logic [BB_W-1:0]     bb_o    [POOL_SLOTS],
  output logic [CNT_W-1:0]    tot_o   [POOL_SLOTS],
  output logic [LEN_W-1:0]    len_o   [POOL_SLOTS],
  output logic [ADDR_W-1:0]   start_o [POOL_SLOTS],
  output logic [3:0]          n_use_o,
  output logic [12:0]         align_bytes_o,
  output logic                busy_o
);

  localparam int BSY_W = $clog2(SETTLE_CYCLES + 1);

  logic [63:0]       sizes_lo_r, sizes_lo_nxt;
  logic [63:0]       sizes_hi_r, sizes_hi_nxt;
  logic [3:0]        bcnt_r, bcnt_nxt;
  logic [3:0]        alog_r, alog_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [BSY_W-1:0]  busy_r, busy_nxt;
  logic [BB_W-1:0]   bb_r    [POOL_SLOTS];
  logic [CNT_W-1:0]  tot_r   [POOL_SLOTS];
  logic [LEN_W-1:0]  len_r   [POOL_SLOTS];
  logic [ADDR_W-1:0] start_r [POOL_SLOTS];
  logic [3:0]        al_sat;
  logic              wr;
  reg_idx_t          idx;

  assign wr      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign idx     = reg_idx_t'(cfg_paddr[5:3]);
  assign cfg_pready = 1'b1;
  assign al_sat  = (alog_r > 4'(ALIGN_MAX_LOG)) ? 4'(ALIGN_MAX_LOG) : alog_r;

  always_comb begin
    sizes_lo_nxt = sizes_lo_r;
    sizes_hi_nxt = sizes_hi_r;
    bcnt_nxt     = bcnt_r;
    alog_nxt     = alog_r;
    base_nxt     = base_r;
    busy_nxt     = (busy_r != '0) ? busy_r - 1'b1 : busy_r;
    if (wr) begin
      unique case (idx)
        REG_SIZES_LO: begin
          sizes_lo_nxt = cfg_pwdata;
          busy_nxt = BSY_W'(SETTLE_CYCLES);
        end
        REG_SIZES_HI: begin
          sizes_hi_nxt = cfg_pwdata;
          busy_nxt = BSY_W'(SETTLE_CYCLES);
        end
        REG_BUCKET_CNT: begin
          bcnt_nxt = cfg_pwdata[3:0];
          busy_nxt = BSY_W'(SETTLE_CYCLES);
        end
        REG_ALIGN_LOG2: begin
          alog_nxt = cfg_pwdata[3:0];
          busy_nxt = BSY_W'(SETTLE_CYCLES);
        end
        REG_HEAP_BASE: begin
          base_nxt = cfg_pwdata[ADDR_W-1:0];
          busy_nxt = BSY_W'(SETTLE_CYCLES);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_lo_r <= 64'h0080_0040_0020_0010;
      sizes_hi_r <= 64'h0800_0400_0200_0100;
      bcnt_r     <= 4'd8;
      alog_r     <= 4'd4;
      base_r     <= '0;
      busy_r     <= BSY_W'(SETTLE_CYCLES);
    end else begin
      sizes_lo_r <= sizes_lo_nxt;
      sizes_hi_r <= sizes_hi_nxt;
      bcnt_r     <= bcnt_nxt;
      alog_r     <= alog_nxt;
      base_r     <= base_nxt;
      busy_r     <= busy_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      size_o[i] = (i < 4) ? sizes_lo_r[16*(i%4) +: 16] : sizes_hi_r[16*(i%4) +: 16];
    end
  end

  // geometry settles through a registered chain of pool starts
  always_ff @(posedge clk) begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      logic [CNT_MAX_W-1:0] n;
      n = block_total(size_o[i]);
      bb_r[i]  <= block_bytes(size_o[i], al_sat);
      tot_r[i] <= CNT_W'((n > CNT_MAX_W'(MAX_BLOCKS)) ? CNT_MAX_W'(MAX_BLOCKS) : n);
      len_r[i] <= {{(LEN_W-BB_W){1'b0}}, bb_r[i]} * {{(LEN_W-CNT_W){1'b0}}, tot_r[i]};
    end
    start_r[0] <= base_r;
    for (int i = 1; i < POOL_SLOTS; i++) begin
      start_r[i] <= start_r[i-1] + {{(ADDR_W-LEN_W){1'b0}}, len_r[i-1]};
    end
  end

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      bb_o[i]    = bb_r[i];
      tot_o[i]   = tot_r[i];
      len_o[i]   = len_r[i];
      start_o[i] = start_r[i];
    end
  end

  assign n_use_o       = (bcnt_r > 4'(POOLS)) ? 4'(POOLS) : bcnt_r;
  assign align_bytes_o = 13'd1 << al_sat;
  assign busy_o        = (busy_r != '0);

  always_comb begin
    unique case (idx)
      REG_SIZES_LO:   cfg_prdata = sizes_lo_r;
      REG_SIZES_HI:   cfg_prdata = sizes_hi_r;
      REG_BUCKET_CNT: cfg_prdata = {60'd0, bcnt_r};
      REG_ALIGN_LOG2: cfg_prdata = {60'd0, alog_r};
      REG_HEAP_BASE:  cfg_prdata = {16'd0, base_r};
      default:        cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/core/ssca_front.sv]
module ssca_front
  import ssca_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int LEN_W      = BB_W + CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_data,
  input  logic [SIZE_W-1:0]   size_i  [POOL_SLOTS],
  input  logic [LEN_W-1:0]    len_i   [POOL_SLOTS],
  input  logic [ADDR_W-1:0]   start_i [POOL_SLOTS],
  input  logic [3:0]          n_use_i,
  input  logic [12:0]         align_bytes_i,
  input  logic                busy_i,
  output logic                q_push,
  output qent_t               q_data,
  input  logic                q_full
);

  logic              fv_r, fv_nxt;
  in_t               item_r;
  logic              accept;
  logic [POOL_SLOTS-1:0] fit;
  logic [3:0]        lo, hi, mid;
  logic [ADDR_W-1:0] off [POOL_SLOTS];
  logic              found;

  assign in_stall = busy_i | (fv_r & q_full);
  assign accept   = in_valid & ~in_stall;
  assign q_push   = fv_r & ~q_full;
  assign fv_nxt   = accept ? 1'b1 : (q_push ? 1'b0 : fv_r);

  always_ff @(posedge clk) begin
    if (!rst_n) fv_r <= 1'b0;
    else        fv_r <= fv_nxt;
  end

  always_ff @(posedge clk) begin
    if (accept) item_r <= in_data;
  end

  always_comb begin
    for (int i = 0; i < POOL_SLOTS; i++) begin
      fit[i] = item_r.req_size <= {16'd0, size_i[i]};
      off[i] = item_r.free_address - start_i[i];
    end
  end

  always_comb begin
    lo = '0;
    hi = n_use_i;
    mid = '0;
    for (int k = 0; k < 4; k++) begin
      if (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (fit[mid[2:0]]) hi = mid;
        else               lo = mid + 4'd1;
      end
    end
  end

  always_comb begin
    q_data = '{kind: K_FINAL, pool: 3'd0, status: ST_OK, off: '0};
    found  = 1'b0;
    if (item_r.cmd == CMD_ALLOC) begin
      if (item_r.req_size == '0) begin
        q_data.status = ST_ZERO_SIZE;
      end else if (item_r.req_align > align_bytes_i) begin
        q_data.status = ST_ALIGN;
      end else if (lo >= n_use_i) begin
        q_data.status = ST_NO_FIT;
      end else begin
        q_data.kind = K_ALLOC;
        q_data.pool = lo[2:0];
      end
    end else begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        if (!found && (4'(i) < n_use_i) &&
            (off[i] < {{(ADDR_W-LEN_W){1'b0}}, len_i[i]})) begin
          found       = 1'b1;
          q_data.kind = K_FREE;
          q_data.pool = 3'(i);
          q_data.off  = OFF_W'(off[i]);
        end
      end
      if (!found) q_data.status = ST_OUTSIDE;
    end
  end

endmodule

[rtl/core/ssca_queue.sv]
module ssca_queue
  import ssca_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  qent_t push_data,
  output logic  full,
  input  logic  pop,
  output qent_t pop_data,
  output logic  empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qent_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;

  assign full     = (cnt_r == CW'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ((wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1) : wp_r;
    rp_nxt  = pop  ? ((rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1) : rp_r;
    cnt_nxt = cnt_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

[rtl/core/ssca_back.sv]
module ssca_back
  import ssca_pkg::*;
#(
  parameter int POOLS      = N_BUCKETS_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1),
  parameter int LEN_W      = BB_W + CNT_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  qent_t               q_data,
  output logic                q_pop,
  input  logic [BB_W-1:0]     bb_i    [POOL_SLOTS],
  input  logic [CNT_W-1:0]    tot_i   [POOL_SLOTS],
  input  logic [ADDR_W-1:0]   start_i [POOL_SLOTS],
  input  logic                busy_i,
  output logic                out_valid,
  input  logic                out_stall,
  output out_t                out_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int SW    = $clog2(IDX_W);
  localparam int DEPTH = POOLS * MAX_BLOCKS;
  localparam int MA_W  = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXEC = 6'b000010,
    S_RD   = 6'b000100,
    S_MUL  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state_r, state_nxt;
  qent_t             ent_r, ent_nxt;
  out_t              res_r, res_nxt;
  out_t              od_r, od_nxt;
  logic              ov_r, ov_nxt;
  logic [CNT_W-1:0]  cnt_r [POOL_SLOTS];
  logic [CNT_W-1:0]  cnt_nxt [POOL_SLOTS];
  logic [CNT_W-1:0]  lw_r  [POOL_SLOTS];
  logic [CNT_W-1:0]  lw_nxt [POOL_SLOTS];
  logic              sel_r, sel_nxt;
  logic [IDX_W-1:0]  cidx_r, cidx_nxt;
  logic [LEN_W-1:0]  prod_r, prod_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]  quo_r, quo_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [IDX_W-1:0]  stack_mem [DEPTH];
  logic [IDX_W-1:0]  rdata_r;
  logic [MA_W-1:0]   rd_addr, wr_addr;
  logic [IDX_W-1:0]  wr_data;
  logic              we;
  logic [CNT_W-1:0]  cur_cnt;
  logic [CNT_W-1:0]  dec_cnt;
  logic [LEN_W-1:0]  trial;
  logic [IDX_W-1:0]  blk;

  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_comb begin
    state_nxt = state_r;
    ent_nxt   = ent_r;
    res_nxt   = res_r;
    ov_nxt    = out_stall ? ov_r : 1'b0;
    od_nxt    = od_r;
    cnt_nxt   = cnt_r;
    lw_nxt    = lw_r;
    sel_nxt   = sel_r;
    cidx_nxt  = cidx_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    q_pop     = 1'b0;
    rd_addr   = '0;
    wr_addr   = '0;
    wr_data   = '0;
    we        = 1'b0;
    cur_cnt   = cnt_r[ent_r.pool];
    dec_cnt   = cur_cnt - 1'b1;
    trial     = {{(LEN_W-BB_W){1'b0}}, bb_i[ent_r.pool]} << step_r;
    blk       = sel_r ? rdata_r : cidx_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_data;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt.block_address = '0;
        res_nxt.bucket        = ent_r.pool;
        res_nxt.status        = ent_r.status;
        state_nxt             = S_DONE;
        case (ent_r.kind)
          K_ALLOC: begin
            if (cur_cnt == '0) begin
              res_nxt.status = ST_EMPTY;
            end else begin
              cnt_nxt[ent_r.pool] = dec_cnt;
              rd_addr   = MA_W'(32'(ent_r.pool) * MAX_BLOCKS + 32'(dec_cnt));
              sel_nxt   = dec_cnt >= lw_r[ent_r.pool];
              cidx_nxt  = IDX_W'(dec_cnt);
              state_nxt = S_RD;
            end
          end
          K_FREE: begin
            if (cur_cnt >= tot_i[ent_r.pool]) begin
              res_nxt.status = ST_FULL;
            end else begin
              rem_nxt   = LEN_W'(ent_r.off);
              quo_nxt   = '0;
              step_nxt  = SW'(IDX_W - 1);
              state_nxt = S_DIV;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        prod_nxt  = {{(LEN_W-IDX_W){1'b0}}, blk} *
                    {{(LEN_W-BB_W){1'b0}}, bb_i[ent_r.pool]};
        state_nxt = S_MUL;
      end
      S_MUL: begin
        res_nxt.block_address = start_i[ent_r.pool] + {{(ADDR_W-LEN_W){1'b0}}, prod_r};
        state_nxt = S_DONE;
      end
      S_DIV: begin
        if (rem_r >= trial) begin
          rem_nxt         = rem_r - trial;
          quo_nxt[step_r] = 1'b1;
        end
        if (step_r == '0) begin
          we      = 1'b1;
          wr_addr = MA_W'(32'(ent_r.pool) * MAX_BLOCKS + 32'(cur_cnt));
          wr_data = quo_nxt;
          cnt_nxt[ent_r.pool] = cur_cnt + 1'b1;
          if (cur_cnt < lw_r[ent_r.pool]) lw_nxt[ent_r.pool] = cur_cnt;
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_DONE: begin
        if (!ov_r || !out_stall) begin
          ov_nxt    = 1'b1;
          od_nxt    = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    // refill: entries at or above the low-water mark hold pushed indices
    if (busy_i) begin
      for (int i = 0; i < POOL_SLOTS; i++) begin
        cnt_nxt[i] = tot_i[i];
        lw_nxt[i]  = CNT_W'(MAX_BLOCKS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      for (int i = 0; i < POOL_SLOTS; i++) begin
        cnt_r[i] <= '0;
        lw_r[i]  <= CNT_W'(MAX_BLOCKS);
      end
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      cnt_r   <= cnt_nxt;
      lw_r    <= lw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    res_r  <= res_nxt;
    od_r   <= od_nxt;
    sel_r  <= sel_nxt;
    cidx_r <= cidx_nxt;
    prod_r <= prod_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) stack_mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    rdata_r <= stack_mem[rd_addr];
  end

endmodule

[rtl/core/slab_size_class_allocator_unit.sv]
// Slab allocator with up to eight size-class pools laid back to back from
// heap_base. An allocate passes from queue to result register through pop,
// classify, stack read, multiply and address add; a free computes its block
// index in a divider that yields one bit per cycle. The front stage and a
// two-entry queue keep taking requests while the back end works, until the
// queue is full. After reset and after every write to a defined register the
// block holds in_stall high while pool geometry settles and all pools are
// refilled.
module slab_size_class_allocator_unit
  import ssca_pkg::*;
#(
  parameter int N_BUCKETS   = N_BUCKETS_DEF,
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_t                in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_t               out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [APB_AW-1:0]  cfg_paddr,
  input  logic [APB_DW-1:0]  cfg_pwdata,
  output logic [APB_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  localparam int POOLS = (N_BUCKETS < POOL_SLOTS) ? N_BUCKETS : POOL_SLOTS;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int LEN_W = BB_W + CNT_W;

  logic [SIZE_W-1:0]  size_w  [POOL_SLOTS];
  logic [BB_W-1:0]    bb_w    [POOL_SLOTS];
  logic [CNT_W-1:0]   tot_w   [POOL_SLOTS];
  logic [LEN_W-1:0]   len_w   [POOL_SLOTS];
  logic [ADDR_W-1:0]  start_w [POOL_SLOTS];
  logic [3:0]         n_use;
  logic [12:0]        align_bytes;
  logic               busy;
  logic               q_push, q_full, q_pop, q_empty;
  qent_t              q_in, q_out;

  ssca_cfg #(.POOLS(POOLS), .MAX_BLOCKS(MAX_BLOCKS), .CNT_W(CNT_W), .LEN_W(LEN_W)) u_cfg (
    .clk, .rst_n,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready,
    .size_o(size_w), .bb_o(bb_w), .tot_o(tot_w), .len_o(len_w), .start_o(start_w),
    .n_use_o(n_use), .align_bytes_o(align_bytes), .busy_o(busy)
  );

  ssca_front #(.MAX_BLOCKS(MAX_BLOCKS), .CNT_W(CNT_W), .LEN_W(LEN_W)) u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_data,
    .size_i(size_w), .len_i(len_w), .start_i(start_w),
    .n_use_i(n_use), .align_bytes_i(align_bytes), .busy_i(busy),
    .q_push, .q_data(q_in), .q_full
  );

  ssca_queue u_queue (
    .clk, .rst_n,
    .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .pop_data(q_out), .empty(q_empty)
  );

  ssca_back #(.POOLS(POOLS), .MAX_BLOCKS(MAX_BLOCKS), .CNT_W(CNT_W), .LEN_W(LEN_W)) u_back (
    .clk, .rst_n,
    .q_empty, .q_data(q_out), .q_pop,
    .bb_i(bb_w), .tot_i(tot_w), .start_i(start_w), .busy_i(busy),
    .out_valid, .out_stall, .out_data
  );

endmodule

[rtl/core/ssca_chk.sv]
module ssca_chk
  import ssca_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.block_address == '0)
    else $error("failed request returned an address");

  a_fail_bucket: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_ZERO_SIZE || out_data.status == ST_ALIGN ||
                  out_data.status == ST_NO_FIT || out_data.status == ST_OUTSIDE)
    |-> out_data.bucket == 3'd0)
    else $error("bucket set on a request that found none");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status != 3'd7)
    else $error("undefined status code");

  a_reset_stall: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> in_stall)
    else $error("input taken before pools were refilled");

endmodule

bind slab_size_class_allocator_unit ssca_chk u_chk (.*);

[test/tb_slab_size_class_allocator_unit.sv]
module tb_slab_size_class_allocator_unit;
  import ssca_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic cfg_pready;

  slab_size_class_allocator_unit i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct {
    in_t  req;
    bit   typed;
    out_t want;
  } row_t;

  // allocator shadow state
  logic [63:0] sz_lo, sz_hi, heap;
  logic [3:0]  nbuck, alog;
  logic [9:0]  free_stk [8][1024];
  int unsigned free_cnt [8];

  out_t        pending_q [$];
  logic [47:0] live_q [$];
  int          errs = 0;
  int          cyc = 0;
  bit          calm = 1'b0;
  out_t        got_e;
  row_t        dir_rows [$];

  function automatic logic [63:0] size_of(int i);
    logic [63:0] w;
    w = (i < 4) ? sz_lo : sz_hi;
    return (w >> (16 * (i % 4))) & 64'hFFFF;
  endfunction

  function automatic int unsigned blocks_of(logic [63:0] s);
    if (s <= 32) return 1024;
    if (s <= 128) return 512;
    if (s <= 512) return 256;
    if (s <= 2048) return 128;
    return 64;
  endfunction

  function automatic logic [63:0] align_bytes();
    return 64'd1 << ((alog > 12) ? 12 : alog);
  endfunction

  function automatic logic [63:0] blk_bytes(logic [63:0] s);
    logic [63:0] a, b;
    a = align_bytes();
    b = (s < 8) ? 64'd8 : s;
    return (b + a - 1) & ~(a - 1);
  endfunction

  function automatic int used_buckets();
    return (nbuck > 8) ? 8 : nbuck;
  endfunction

  function automatic logic [63:0] pool_base(int idx);
    logic [63:0] st;
    st = heap & MASK48;
    for (int i = 0; i < idx; i++)
      st = (st + blk_bytes(size_of(i)) * blocks_of(size_of(i))) & MASK48;
    return st;
  endfunction

  function automatic void refill_pools();
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 1024; k++) free_stk[i][k] = k[9:0];
      free_cnt[i] = blocks_of(size_of(i));
    end
    live_q.delete();
  endfunction

  function automatic out_t alloc_free_step(in_t d);
    out_t r;
    int n, lo, hi, mid;
    logic [63:0] a, st, bb, off;
    int unsigned c, tot;
    bit hit;
    r = '0;
    r.status = ST_OK;
    n = used_buckets();
    if (d.cmd == CMD_ALLOC) begin
      if (d.req_size == 0) begin
        r.status = ST_ZERO_SIZE;
      end else if (64'(d.req_align) > align_bytes()) begin
        r.status = ST_ALIGN;
      end else begin
        lo = 0;
        hi = n;
        while (lo < hi) begin
          mid = lo + (hi - lo) / 2;
          if (64'(d.req_size) <= size_of(mid)) hi = mid;
          else lo = mid + 1;
        end
        if (lo >= n) begin
          r.status = ST_NO_FIT;
        end else if (free_cnt[lo] == 0) begin
          r.status = ST_EMPTY;
          r.bucket = lo[2:0];
        end else begin
          c = free_cnt[lo] - 1;
          free_cnt[lo] = c;
          a = pool_base(lo) + 64'(free_stk[lo][c]) * blk_bytes(size_of(lo));
          r.block_address = a[47:0];
          r.bucket = lo[2:0];
        end
      end
    end else begin
      a = 64'(d.free_address);
      st = heap & MASK48;
      hit = 1'b0;
      for (int i = 0; i < n && !hit; i++) begin
        bb = blk_bytes(size_of(i));
        tot = blocks_of(size_of(i));
        off = (a - st) & MASK48;
        if (off < bb * tot) begin
          hit = 1'b1;
          r.bucket = i[2:0];
          if (free_cnt[i] >= tot) begin
            r.status = ST_FULL;
          end else begin
            free_stk[i][free_cnt[i]] = 10'(off / bb);
            free_cnt[i]++;
          end
        end
        st = (st + bb * tot) & MASK48;
      end
      if (!hit) r.status = ST_OUTSIDE;
    end
    return r;
  endfunction

  task automatic send_req(in_t d, bit typed, out_t want);
    out_t p;
    if (!calm && $urandom_range(0, 99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall);
    p = alloc_free_step(d);
    if (d.cmd == CMD_ALLOC && p.status == ST_OK) live_q.push_back(p.block_address);
    pending_q.push_back(typed ? want : p);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic reg_write(reg_idx_t r, logic [63:0] v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= APB_AW'({r, 3'b000});
    cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    case (r)
      REG_SIZES_LO:   sz_lo = v;
      REG_SIZES_HI:   sz_hi = v;
      REG_BUCKET_CNT: nbuck = v[3:0];
      REG_ALIGN_LOG2: alog = v[3:0];
      REG_HEAP_BASE:  heap = v & MASK48;
      default: ;
    endcase
    refill_pools();
  endtask

  task automatic set_all(logic [63:0] lo, logic [63:0] hi, logic [3:0] bc,
                         logic [3:0] al, logic [63:0] hb);
    drain();
    reg_write(REG_SIZES_LO, lo);
    reg_write(REG_SIZES_HI, hi);
    reg_write(REG_BUCKET_CNT, 64'(bc));
    reg_write(REG_ALIGN_LOG2, 64'(al));
    reg_write(REG_HEAP_BASE, hb);
  endtask

  function automatic in_t make_req(logic c, logic [31:0] s, logic [12:0] al, logic [47:0] fa);
    in_t d;
    d.cmd = c;
    d.req_size = s;
    d.req_align = al;
    d.free_address = fa;
    return d;
  endfunction

  function automatic out_t make_res(logic [47:0] a, logic [2:0] b, status_t s);
    out_t r;
    r.block_address = a;
    r.bucket = b;
    r.status = s;
    return r;
  endfunction

  function automatic void add_row(in_t d, bit typed, out_t want);
    row_t r;
    r.req = d;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic in_t rand_req(int alloc_pct);
    in_t d;
    int k, b;
    logic [63:0] a;
    d = make_req(CMD_ALLOC, $urandom, 13'($urandom), {16'($urandom), 32'($urandom)});
    k = $urandom_range(0, 99);
    if (k < alloc_pct) begin
      b = $urandom_range(0, 7);
      case ($urandom_range(0, 9))
        0: d.req_size = 0;
        1: ;
        2: d.req_size = 32'(size_of(b)) + 1;
        default: d.req_size = 32'(size_of(b)) - $urandom_range(0, 3);
      endcase
      case ($urandom_range(0, 5))
        0: ;
        1: d.req_align = 0;
        default: d.req_align = 13'(align_bytes() >> $urandom_range(0, 4));
      endcase
    end else if (k < 90) begin
      d.cmd = CMD_FREE;
      if (live_q.size() != 0 && $urandom_range(0, 9) != 0) begin
        b = $urandom_range(0, live_q.size() - 1);
        d.free_address = live_q[b] + ($urandom_range(0, 3) == 0 ? $urandom_range(1, 7) : 0);
        if ($urandom_range(0, 7) != 0) live_q.delete(b);
      end else begin
        a = pool_base($urandom_range(0, 8)) + $urandom_range(0, 255) - 8;
        d.free_address = a[47:0];
      end
    end else begin
      d.cmd = 1'($urandom);
    end
    return d;
  endfunction

  task automatic run_random(int cnt, int alloc_pct);
    for (int i = 0; i < cnt; i++) begin
      calm = (i >= cnt / 3 && i < cnt / 2);
      if (i == cnt / 2) drain();
      send_req(rand_req(alloc_pct), 1'b0, '0);
    end
    calm = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: %p", out_data);
        errs++;
      end else begin
        got_e = pending_q.pop_front();
        if (out_data.block_address !== got_e.block_address) begin
          $error("block_address: expected %h, got %h", got_e.block_address,
                 out_data.block_address);
          errs++;
        end
        if (out_data.bucket !== got_e.bucket) begin
          $error("bucket: expected %0d, got %0d", got_e.bucket, out_data.bucket);
          errs++;
        end
        if (out_data.status !== got_e.status) begin
          $error("status: expected %0d, got %0d", got_e.status, out_data.status);
          errs++;
        end
      end
    end
    out_stall <= !calm && ($urandom_range(0, 99) < 22);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    sz_lo = 64'd36029071898968080;
    sz_hi = 64'd576465150383489280;
    nbuck = 4'd8;
    alog = 4'd4;
    heap = 64'd0;
    refill_pools();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_row(make_req(CMD_ALLOC, 32'd0, 13'd0, '0), 1, make_res('0, 3'd0, ST_ZERO_SIZE));
    add_row(make_req(CMD_ALLOC, 32'd1, 13'd32, '0), 1, make_res('0, 3'd0, ST_ALIGN));
    add_row(make_req(CMD_ALLOC, 32'd1, 13'h1FFF, '1), 1, make_res('0, 3'd0, ST_ALIGN));
    add_row(make_req(CMD_ALLOC, 32'd2049, 13'd0, '0), 1, make_res('0, 3'd0, ST_NO_FIT));
    add_row(make_req(CMD_ALLOC, 32'hFFFF_FFFF, 13'd16, '0), 1, make_res('0, 3'd0, ST_NO_FIT));
    add_row(make_req(CMD_ALLOC, 32'd1, 13'd16, '0), 1, make_res(48'd16368, 3'd0, ST_OK));
    add_row(make_req(CMD_ALLOC, 32'd2048, 13'd1, '0), 0, '0);
    add_row(make_req(CMD_ALLOC, 32'd17, 13'd0, '0), 0, '0);
    add_row(make_req(CMD_FREE, 32'd0, 13'd0, 48'd0), 0, '0);
    add_row(make_req(CMD_FREE, 32'd0, 13'd0, 48'd0), 1, make_res('0, 3'd0, ST_FULL));
    add_row(make_req(CMD_FREE, '1, '1, '1), 1, make_res('0, 3'd0, ST_OUTSIDE));
    add_row(make_req(CMD_ALLOC, 32'd100, 13'd8, '0), 0, '0);
    add_row(make_req(CMD_FREE, 32'd0, 13'd0, 48'd16384 + 48'd1023 * 48'd32 + 48'd7), 0, '0);
    add_row(make_req(CMD_FREE, 32'd0, 13'd0, 48'd16384 + 48'd5), 1,
            make_res('0, 3'd1, ST_FULL));
    add_row(make_req(CMD_FREE, 32'd0, 13'd0, 48'd100), 1, make_res('0, 3'd0, ST_FULL));
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

    run_random(280, 50);

    // two large-block pools, byte alignment: pools run empty
    set_all({16'd3072, 16'd3072, 16'd3000, 16'd2049}, {4{16'd4096}}, 4'd2, 4'd0,
            64'h1234_5678);
    run_random(280, 80);

    // tiny and huge sizes, saturating alignment, heap wraps past the top
    set_all({16'd33, 16'd9, 16'd8, 16'd1}, {16'hFFFF, 16'd2049, 16'd513, 16'd129},
            4'd15, 4'd15, 64'hFFFF_FFFF_8000);
    run_random(280, 55);

    set_all('1, '0, 4'd0, 4'd12, 64'hFFFF_FFFF_FFFF);
    run_random(120, 50);

    set_all({$urandom, $urandom}, {$urandom, $urandom}, 4'd1, 4'($urandom_range(0, 15)),
            {$urandom, $urandom});
    run_random(200, 60);

    set_all({$urandom, $urandom}, {$urandom, $urandom}, 4'($urandom_range(1, 8)),
            4'($urandom_range(0, 12)), {$urandom, $urandom});
    run_random(240, 55);

    set_all(64'd36029071898968080, 64'd576465150383489280, 4'd8, 4'd3, 64'h8000);
    run_random(300, 55);

    drain();
    if (errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/ssca_pkg.sv
rtl/core/ssca_cfg.sv
rtl/core/ssca_front.sv
rtl/core/ssca_queue.sv
rtl/core/ssca_back.sv
rtl/core/slab_size_class_allocator_unit.sv
rtl/core/ssca_chk.sv
test/tb_slab_size_class_allocator_unit.sv
